// ===== rtl/core/kcl_pkg.sv =====
// Shared types and constants for the keypad code lock.
package kcl_pkg;

  localparam int unsigned CodeLen = 4;
  localparam int unsigned DigitW  = 6;
  localparam int unsigned TickW   = 4;
  localparam int unsigned LightW  = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 8;

  localparam logic [ByteW-1:0] LightFirst = 8'h41;
  localparam logic [ByteW-1:0] LightLast  = 8'h48;
  localparam logic [ByteW-1:0] DigitFirst = 8'h30;
  localparam logic [ByteW-1:0] DigitLast  = 8'h39;

  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  localparam logic [1:0] ReplyNone = 2'd0;
  localparam logic [1:0] ReplyOk   = 2'd1;
  localparam logic [1:0] ReplyFail = 2'd2;

  localparam logic [CfgIdxW-1:0] RegCode0  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCode1  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCode2  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCode3  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBeepOn = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPeriod = 3'd5;

  localparam logic [DigitW-1:0] Code0Rst  = 6'd49;
  localparam logic [DigitW-1:0] Code1Rst  = 6'd50;
  localparam logic [DigitW-1:0] Code2Rst  = 6'd51;
  localparam logic [DigitW-1:0] Code3Rst  = 6'd52;
  localparam logic [TickW-1:0]  BeepOnRst = 4'd5;
  localparam logic [TickW-1:0]  PeriodRst = 4'd10;

  typedef struct packed {
    logic [CodeLen-1:0][DigitW-1:0] code;
    logic [TickW-1:0]               beep_on;
    logic [TickW-1:0]               period;
  } cfg_t;

  typedef struct packed {
    logic [LightW-1:0] light_bits;
    logic              armed;
    logic              sounding;
    logic              buzzer;
    logic [1:0]        reply_code;
  } rslt_t;

endpackage

// ===== rtl/core/kcl_cfg_regs.sv =====
// Configuration register file for the keypad code lock.
module kcl_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [kcl_pkg::CfgIdxW-1:0]  wr_idx,
  input  logic [kcl_pkg::CfgDatW-1:0]  wr_data,
  output kcl_pkg::cfg_t                cfg
);
  import kcl_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code[0] <= Code0Rst;
      cfg_r.code[1] <= Code1Rst;
      cfg_r.code[2] <= Code2Rst;
      cfg_r.code[3] <= Code3Rst;
      cfg_r.beep_on <= BeepOnRst;
      cfg_r.period  <= PeriodRst;
    end else if (wr_en) begin
      case (wr_idx)
        RegCode0:  cfg_r.code[0] <= wr_data[DigitW-1:0];
        RegCode1:  cfg_r.code[1] <= wr_data[DigitW-1:0];
        RegCode2:  cfg_r.code[2] <= wr_data[DigitW-1:0];
        RegCode3:  cfg_r.code[3] <= wr_data[DigitW-1:0];
        RegBeepOn: cfg_r.beep_on <= wr_data[TickW-1:0];
        RegPeriod: cfg_r.period  <= wr_data[TickW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/kcl_step.sv =====
// Lock state, light state and beep sequencer with next-result logic.
module kcl_step (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  logic                       opcode,
  input  logic [kcl_pkg::ByteW-1:0]  rx_byte,
  input  kcl_pkg::cfg_t              cfg,
  output kcl_pkg::rslt_t             rslt
);
  import kcl_pkg::*;

  logic [LightW-1:0] lights_r, lights_nxt;
  logic [1:0]        dcnt_r, dcnt_nxt;
  logic              match_r, match_nxt;
  logic              armed_r, armed_nxt;
  logic              sound_r, sound_nxt;
  logic [TickW-1:0]  phase_r, phase_nxt;
  logic              buzz_r, buzz_nxt;
  logic [1:0]        reply;
  logic [2:0]        light_off;
  logic [TickW:0]    phase_inc;
  logic              digit_hit;
  logic              entry_match;

  always_comb begin
    lights_nxt  = lights_r;
    dcnt_nxt    = dcnt_r;
    match_nxt   = match_r;
    armed_nxt   = armed_r;
    sound_nxt   = sound_r;
    phase_nxt   = phase_r;
    buzz_nxt    = buzz_r;
    reply       = ReplyNone;
    light_off   = 3'(rx_byte - LightFirst);
    phase_inc   = {1'b0, phase_r} + 1'b1;
    digit_hit   = (rx_byte == {2'b00, cfg.code[dcnt_r]});
    entry_match = match_r && digit_hit;
    if (opcode == OpTick) begin
      if (sound_r) begin
        buzz_nxt  = (phase_r < cfg.beep_on);
        phase_nxt = (phase_inc >= {1'b0, cfg.period}) ? '0 : phase_inc[TickW-1:0];
      end
    end else if (rx_byte inside {[LightFirst:LightLast]}) begin
      lights_nxt[light_off[2:1]] = ~light_off[0];
    end else if (rx_byte inside {[DigitFirst:DigitLast]}) begin
      dcnt_nxt  = dcnt_r + 2'd1;
      match_nxt = entry_match;
      if (dcnt_r == 2'(CodeLen - 1)) begin
        match_nxt = 1'b1;
        if (entry_match) begin
          reply     = ReplyOk;
          armed_nxt = ~armed_r;
          sound_nxt = 1'b0;
        end else begin
          reply = ReplyFail;
          if (armed_r) begin
            sound_nxt = 1'b1;
          end
        end
      end
    end
    if (!sound_nxt) begin
      buzz_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lights_r <= '0;
      dcnt_r   <= '0;
      match_r  <= 1'b1;
      armed_r  <= 1'b0;
      sound_r  <= 1'b0;
      phase_r  <= '0;
      buzz_r   <= 1'b0;
    end else if (step_en) begin
      lights_r <= lights_nxt;
      dcnt_r   <= dcnt_nxt;
      match_r  <= match_nxt;
      armed_r  <= armed_nxt;
      sound_r  <= sound_nxt;
      phase_r  <= phase_nxt;
      buzz_r   <= buzz_nxt;
    end
  end

  assign rslt.light_bits = lights_nxt;
  assign rslt.armed      = armed_nxt;
  assign rslt.sounding   = sound_nxt;
  assign rslt.buzzer     = buzz_nxt;
  assign rslt.reply_code = reply;

  a_buzz_needs_sound: assert property (@(posedge clk) disable iff (!rst_n)
    buzz_r |-> sound_r)
    else $error("buzzer high while alarm silent");

  a_ok_toggles_armed: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && reply == ReplyOk |=> armed_r != $past(armed_r) && !sound_r)
    else $error("accepted code did not toggle armed and silence");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(lights_r) && $stable(dcnt_r) && $stable(armed_r)
                 && $stable(sound_r) && $stable(phase_r))
    else $error("state changed without a request");

  a_reply_on_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && reply != ReplyNone |=> dcnt_r == 2'd0 && match_r)
    else $error("reply outside the end of a code entry");

endmodule

// ===== rtl/core/keypad_code_lock_with_alarm.sv =====
// Top level of the keypad code lock with alarm.
// Each request (a command byte or a timer tick) is taken into an input register, processed
// combinationally by the state logic and written to a result register, so one request per
// clock is sustained while out_stall is low, and every request yields exactly one result.
// The result register drives the outputs. The result register and the input register each hold one
// request, so a stalled output lets one more request in before in_stall rises.
// Configuration writes are always ready and must be issued only while no request is in flight.
module keypad_code_lock_with_alarm (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [kcl_pkg::ByteW-1:0]    in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [kcl_pkg::LightW-1:0]   out_light_bits,
  output logic                         out_armed,
  output logic                         out_sounding,
  output logic                         out_buzzer,
  output logic [1:0]                   out_reply_code,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [kcl_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [kcl_pkg::CfgDatW-1:0]  cfg_data
);
  import kcl_pkg::*;

  cfg_t              cfg;
  rslt_t             rslt;
  rslt_t             res_r;
  logic              stg_vld_r;
  logic              stg_op_r;
  logic [ByteW-1:0]  stg_byte_r;
  logic              out_vld_r;
  logic              out_free;
  logic              step_en;
  logic              in_take;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_vld_r || !out_stall;
  assign step_en   = stg_vld_r && out_free;
  assign in_stall  = stg_vld_r && !out_free;
  assign in_take   = in_valid && !in_stall;

  kcl_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  kcl_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .opcode  (stg_op_r),
    .rx_byte (stg_byte_r),
    .cfg     (cfg),
    .rslt    (rslt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        stg_vld_r <= in_valid;
      end
      if (out_free) begin
        out_vld_r <= stg_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_op_r   <= in_opcode;
      stg_byte_r <= in_rx_byte;
    end
    if (step_en) begin
      res_r <= rslt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_light_bits = res_r.light_bits;
  assign out_armed      = res_r.armed;
  assign out_sounding   = res_r.sounding;
  assign out_buzzer     = res_r.buzzer;
  assign out_reply_code = res_r.reply_code;

endmodule

// ===== verif/keypad_code_lock_with_alarm_test.sv =====
// Self-checking testbench for the keypad code lock: lights, code entry, alarm beeps and backpressure.
`timescale 1ns / 1ps

module keypad_code_lock_with_alarm_test;
  import kcl_pkg::*;

  localparam int HoldCycles = 60;
  localparam int WatchLimit = 1000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_opcode;
  logic [ByteW-1:0] in_rx_byte;
  logic out_valid;
  logic out_stall;
  logic [LightW-1:0] out_light_bits;
  logic out_armed;
  logic out_sounding;
  logic out_buzzer;
  logic [1:0] out_reply_code;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDatW-1:0] cfg_data;

  // lock state and register copies
  logic [LightW-1:0] p_lights = '0;
  logic [1:0] p_digits = '0;
  logic p_match = 1'b1;
  logic p_armed = 1'b0;
  logic p_sound = 1'b0;
  logic [TickW-1:0] p_phase = '0;
  logic p_buzz = 1'b0;
  logic [DigitW-1:0] reg_code [CodeLen] = '{Code0Rst, Code1Rst, Code2Rst, Code3Rst};
  logic [TickW-1:0] reg_on = BeepOnRst;
  logic [TickW-1:0] reg_period = PeriodRst;

  rslt_t status_due [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  bit hold_req = 1'b0;
  bit steady = 1'b0;

  keypad_code_lock_with_alarm dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_light_bits(out_light_bits),
    .out_armed     (out_armed),
    .out_sounding  (out_sounding),
    .out_buzzer    (out_buzzer),
    .out_reply_code(out_reply_code),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic rslt_t predict_lock_status(logic op, logic [ByteW-1:0] b);
    rslt_t r;
    logic [1:0] reply;
    logic [ByteW-1:0] off;
    int nxt;
    reply = ReplyNone;
    if (op == OpTick) begin
      if (p_sound) begin
        p_buzz = p_phase < reg_on;
        nxt = p_phase + 1;
        p_phase = (nxt >= reg_period) ? '0 : nxt[TickW-1:0];
      end
    end else if (b >= LightFirst && b <= LightLast) begin
      off = b - LightFirst;
      p_lights[off[2:1]] = ~off[0];
    end else if (b >= DigitFirst && b <= DigitLast) begin
      if (b != {2'b00, reg_code[p_digits]}) p_match = 1'b0;
      p_digits = p_digits + 2'd1;
      if (p_digits == 2'd0) begin
        if (p_match) begin
          reply = ReplyOk;
          p_armed = ~p_armed;
          p_sound = 1'b0;
        end else begin
          reply = ReplyFail;
          if (p_armed) p_sound = 1'b1;
        end
        p_match = 1'b1;
      end
    end
    if (!p_sound) p_buzz = 1'b0;
    r.light_bits = p_lights;
    r.armed = p_armed;
    r.sounding = p_sound;
    r.buzzer = p_buzz;
    r.reply_code = reply;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    rslt_t seen;
    rslt_t due;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        moved = 1'b1;
        seen = {out_light_bits, out_armed, out_sounding, out_buzzer, out_reply_code};
        if (status_due.size() == 0) begin
          $error("result with no request pending");
          mismatches++;
        end else begin
          due = status_due.pop_front();
          check_field("light_bits", 8'(due.light_bits), 8'(seen.light_bits));
          check_field("armed", 8'(due.armed), 8'(seen.armed));
          check_field("sounding", 8'(due.sounding), 8'(seen.sounding));
          check_field("buzzer", 8'(due.buzzer), 8'(seen.buzzer));
          check_field("reply_code", 8'(due.reply_code), 8'(seen.reply_code));
        end
      end
      if (cfg_valid && cfg_ready === 1'b1) begin
        moved = 1'b1;
        case (cfg_index)
          RegCode0, RegCode1, RegCode2, RegCode3: reg_code[cfg_index[1:0]] = cfg_data[DigitW-1:0];
          RegBeepOn: reg_on = cfg_data[TickW-1:0];
          RegPeriod: reg_period = cfg_data[TickW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_stall === 1'b0) begin
        moved = 1'b1;
        status_due.push_back(predict_lock_status(in_opcode, in_rx_byte));
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < WatchLimit) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (gap_len()) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // enter at a falling edge, return at the falling edge after the request is taken
  task automatic send_req(logic op, logic [ByteW-1:0] b);
    int gap;
    if (!steady && $urandom_range(0, 3) == 0) begin
      gap = gap_len();
      in_valid <= 1'b0;
      in_opcode <= 1'($urandom_range(0, 1));
      in_rx_byte <= 8'($urandom_range(0, 255));
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_code(logic [31:0] s, logic [1:0] top);
    for (int i = 0; i < CodeLen; i++) write_reg(CfgIdxW'(RegCode0 + i), {top, s[24-8*i +: 6]});
  endtask

  task automatic set_timing(logic [CfgDatW-1:0] on_data, logic [CfgDatW-1:0] period_data);
    write_reg(RegBeepOn, on_data);
    write_reg(RegPeriod, period_data);
  endtask

  task automatic send_code(logic [31:0] s);
    for (int i = 0; i < CodeLen; i++) send_req(OpByte, s[24-8*i +: 8]);
  endtask

  function automatic logic [31:0] rand_code();
    logic [31:0] s;
    for (int i = 0; i < CodeLen; i++) s[24-8*i +: 8] = DigitFirst + 8'($urandom_range(0, 9));
    return s;
  endfunction

  task automatic enter_code(bit right);
    int bad;
    logic [ByteW-1:0] d;
    bad = right ? -1 : $urandom_range(0, 3);
    for (int i = 0; i < CodeLen; i++) begin
      d = {2'b00, reg_code[i]};
      if (i == bad) begin
        d = DigitFirst + 8'($urandom_range(0, 9));
        if (d == {2'b00, reg_code[i]}) d = (d == DigitLast) ? DigitFirst : d + 8'd1;
      end
      send_req(OpByte, d);
    end
  endtask

  task automatic run_random(int n);
    int done;
    int k;
    int len;
    done = 0;
    while (done < n) begin
      k = $urandom_range(0, 99);
      if (k < 30) begin
        enter_code(1'b1);
        done += 4;
      end else if (k < 50) begin
        enter_code(1'b0);
        done += 4;
      end else if (k < 72) begin
        len = $urandom_range(1, 24);
        repeat (len) send_req(OpTick, 8'($urandom_range(0, 255)));
        done += len;
      end else if (k < 86) begin
        send_req(OpByte, LightFirst + 8'($urandom_range(0, 7)));
        done++;
      end else begin
        send_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        done++;
      end
    end
  endtask

  task automatic test_lights();
    send_req(OpByte, "A");
    send_req(OpByte, "C");
    send_req(OpByte, "E");
    send_req(OpByte, "G");
    send_req(OpByte, "B");
    send_req(OpByte, "D");
    send_req(OpByte, "F");
    send_req(OpByte, "H");
    send_req(OpByte, "@");
    send_req(OpByte, "I");
  endtask

  task automatic test_code_and_alarm();
    send_req(OpTick, 8'hFF);
    send_code("1234");
    send_code("1239");
    send_req(OpTick, 8'h00);
    send_req(OpTick, 8'h00);
    send_code("5234");
    send_code("1234");
    send_code("0000");
  endtask

  task automatic test_register_settings();
    run_random(150);
    set_code(rand_code(), 2'b11);
    set_timing(8'hF1, 8'h02);
    run_random(170);
    // leave an entry half done across the code change
    wait_idle();
    send_req(OpByte, {2'b00, reg_code[0]});
    send_req(OpByte, {2'b00, reg_code[1]});
    set_code("0909", 2'b10);
    set_timing(8'h0F, 8'h0F);
    run_random(170);
    set_timing(8'h0F, 8'h02);
    run_random(170);
    set_timing(8'h13, 8'hF0);
    run_random(170);
    set_timing(8'h01, 8'h01);
    write_reg(RegCode3, 8'h3F);
    run_random(150);
    set_code(rand_code(), 2'b01);
    write_reg(RegCode1, 8'h00);
    set_timing(8'h01, 8'h0F);
    run_random(150);
    set_code("1234", 2'b00);
    set_timing(8'h05, 8'h0A);
    steady = 1'b1;
    run_random(150);
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    steady = 1'b1;
    hold_req = 1'b1;
    run_random(100);
    steady = 1'b0;
    run_random(100);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OpByte;
    in_rx_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = RegCode0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_lights();
    test_code_and_alarm();
    test_register_settings();
    test_backpressure();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
